// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the lock manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define CLM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define CLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/clm_pkg.sv =====
// Types and codes shared by the lock manager modules.
package clm_pkg;

   localparam int CMD_W       = 2;
   localparam int LOCK_ID_W   = 6;
   localparam int CLIENT_W    = 4;
   localparam int STATUS_W    = 2;
   localparam int KIND_W      = 2;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - STATUS_W - CLIENT_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_ACQUIRE      = 2'd0,
      CMD_RELEASE      = 2'd1,
      CMD_RETRY_RESULT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      PH_FREE     = 2'd0,
      PH_HELD     = 2'd1,
      PH_REVOKING = 2'd2,
      PH_HANDOVER = 2'd3
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 2'd0,
      ST_RETRY      = 2'd1,
      ST_NOT_HOLDER = 2'd2,
      ST_FULL       = 2'd3
   } status_type;

   typedef enum logic [KIND_W-1:0] {
      MSG_NONE   = 2'd0,
      MSG_REVOKE = 2'd1,
      MSG_RETRY  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_POP
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic clearing;
      logic load;
      logic commit;
      logic commit_pop;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_done;
      logic need_pop;
   } dp_status_type;

   typedef struct packed {
      logic [CLIENT_W-1:0] client;
      kind_type            kind;
      status_type          status;
   } result_type;

endpackage

// ===== rtl/clm_ctrl.sv =====
// Sequencing state machine of the lock manager.
module clm_ctrl
   import clm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type dp_status,
   input  logic          out_free,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clearing = 1'b1;
            if (dp_status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (dp_status.need_pop) begin
               state_in = S_POP;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_POP: begin
            if (out_free) begin
               cmd.commit_pop = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/clm_datapath.sv =====
// Lock table, wait queues and decision logic of the lock manager.
module clm_datapath
   import clm_pkg::*;
#(
   parameter int LOCK_COUNT   = 64,
   parameter int CLIENT_COUNT = 16,
   parameter int QUEUE_DEPTH  = 8
)(
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [LOCK_ID_W-1:0] req_lock_id,
   input  logic [CLIENT_W-1:0]  req_client_id,
   input  logic                 req_retry_ok,
   output dp_status_type        dp_status,
   output result_type           result
);

   localparam int LOCK_AW     = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
   localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH = LOCK_COUNT * QUEUE_DEPTH;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int IDX_EXT_W   = LOCK_AW + LOCK_ID_W;

   typedef struct packed {
      phase_type           phase;
      logic [CLIENT_W-1:0] holder;
      logic [SLOT_W-1:0]   head;
      logic [COUNT_W-1:0]  count;
   } row_type;

   row_type             row_mem   [LOCK_COUNT];
   logic [CLIENT_W-1:0] store_mem [STORE_DEPTH];

   logic [CMD_W-1:0]     cmd_ff;
   logic [LOCK_ID_W-1:0] lock_ff;
   logic [CLIENT_W-1:0]  client_ff;
   logic                 ok_ff;
   logic [LOCK_AW-1:0]   clear_cnt_ff;

   logic [IDX_EXT_W-1:0] req_idx_ext, item_idx_ext;
   logic [LOCK_AW-1:0]   item_idx, rd_idx, row_wa;
   row_type              row_q, row_next, row_pop, row_wd;
   logic                 row_we, row_dirty;
   logic [CLIENT_W-1:0]  store_q;
   logic [STORE_AW-1:0]  push_addr, head_addr;
   logic                 push, push_we, need_pop, range_ok, full;
   logic [SLOT_W:0]      slot_sum;
   logic [SLOT_W-1:0]    tail_slot, head_next;
   result_type           res_dec, res_pop;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff    <= req_command;
         lock_ff   <= req_lock_id;
         client_ff <= req_client_id;
         ok_ff     <= req_retry_ok;
      end
   end

   // Clearing pass over the lock table after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clearing && !dp_status.clear_done) begin
         clear_cnt_ff <= clear_cnt_ff + LOCK_AW'(1);
      end
   end

   assign req_idx_ext  = IDX_EXT_W'(req_lock_id);
   assign item_idx_ext = IDX_EXT_W'(lock_ff);
   assign item_idx     = item_idx_ext[LOCK_AW-1:0];
   assign rd_idx       = cmd.load ? req_idx_ext[LOCK_AW-1:0] : item_idx;

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_wa] <= row_wd;
      end
      row_q <= row_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (push_we) begin
         store_mem[push_addr] <= client_ff;
      end
      store_q <= store_mem[head_addr];
   end

   // Queue slot arithmetic
   always_comb begin
      slot_sum  = {1'b0, row_q.head} + (SLOT_W + 1)'(row_q.count);
      tail_slot = (slot_sum >= (SLOT_W + 1)'(QUEUE_DEPTH))
                  ? SLOT_W'(slot_sum - (SLOT_W + 1)'(QUEUE_DEPTH))
                  : SLOT_W'(slot_sum);
      head_next = (row_q.head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                  : row_q.head + SLOT_W'(1);
      full      = row_q.count >= COUNT_W'(QUEUE_DEPTH);
      push_addr = STORE_AW'(item_idx) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(tail_slot);
      head_addr = STORE_AW'(item_idx) * STORE_AW'(QUEUE_DEPTH) + STORE_AW'(row_q.head);
      range_ok  = (32'(lock_ff) < 32'(LOCK_COUNT)) && (32'(client_ff) < 32'(CLIENT_COUNT));
   end

   // Decide the outcome of the held item
   always_comb begin
      row_next  = row_q;
      row_dirty = 1'b0;
      push      = 1'b0;
      need_pop  = 1'b0;
      res_dec   = '{client: '0, kind: MSG_NONE, status: ST_OK};
      if (!range_ok) begin
         res_dec.status = ST_NOT_HOLDER;
      end else begin
         case (cmd_ff)
            CMD_ACQUIRE: begin
               if (row_q.phase == PH_FREE) begin
                  row_next.holder = client_ff;
                  row_next.phase  = PH_HELD;
                  row_dirty       = 1'b1;
               end else if (full) begin
                  res_dec.status = ST_FULL;
               end else begin
                  push           = 1'b1;
                  row_next.count = row_q.count + COUNT_W'(1);
                  row_dirty      = 1'b1;
                  res_dec.status = ST_RETRY;
                  if (row_q.phase == PH_HELD) begin
                     row_next.phase = PH_REVOKING;
                     res_dec.kind   = MSG_REVOKE;
                     res_dec.client = row_q.holder;
                  end
               end
            end
            CMD_RELEASE: begin
               if (row_q.phase == PH_FREE || row_q.holder != client_ff) begin
                  res_dec.status = ST_NOT_HOLDER;
               end else if (row_q.count != '0) begin
                  need_pop = 1'b1;
               end else begin
                  row_next.phase = PH_FREE;
                  row_dirty      = 1'b1;
               end
            end
            CMD_RETRY_RESULT: begin
               if (!ok_ff || row_q.phase != PH_HANDOVER) begin
                  res_dec.status = ST_OK;
               end else if (row_q.holder != client_ff) begin
                  res_dec.status = ST_NOT_HOLDER;
               end else begin
                  row_next.phase = PH_HELD;
                  row_dirty      = 1'b1;
               end
            end
            default: begin
               res_dec.status = ST_OK;
            end
         endcase
      end
   end

   // Hand the lock to the head of its queue
   always_comb begin
      row_pop        = row_q;
      row_pop.holder = store_q;
      row_pop.phase  = PH_HANDOVER;
      row_pop.head   = head_next;
      row_pop.count  = row_q.count - COUNT_W'(1);
      res_pop        = '{client: store_q, kind: MSG_RETRY, status: ST_OK};
   end

   always_comb begin
      row_we  = cmd.clearing | (cmd.commit & row_dirty) | cmd.commit_pop;
      row_wa  = cmd.clearing ? clear_cnt_ff : item_idx;
      row_wd  = cmd.clearing ? row_type'('0) : (cmd.commit_pop ? row_pop : row_next);
      push_we = cmd.commit & push;
      result  = cmd.commit_pop ? res_pop : res_dec;
   end

   assign dp_status.clear_done = (clear_cnt_ff == LOCK_AW'(LOCK_COUNT - 1));
   assign dp_status.need_pop   = need_pop;

endmodule

// ===== rtl/caching_lock_manager_core.sv =====
// Top level of the caching lock manager: request and response streams.
//
//   channel | prefix | direction | tdata (low bit up)                   | tuser
//   --------+--------+-----------+--------------------------------------+------------
//   request | req_   | in        | lock_id[5:0] client_id[9:6] retry_ok | command
//   result  | rsp_   | out       | status[1:0] notify_client[5:2]       | notify_kind
//
// An item is accepted, then its lock entry is read, modified and written;
// a release that hands the lock to a waiter adds a step that reads the
// head slot of the wait queue memory.
// After reset the lock table is cleared one entry a cycle, with req_tready
// low until the last entry is cleared.
// One item is in flight at a time; a result waits in the output register
// and holds the next item in its final cycle until rsp_tready frees it.
module caching_lock_manager_core
   import clm_pkg::*;
#(
   parameter int LOCK_COUNT   = 64,
   parameter int CLIENT_COUNT = 16,
   parameter int QUEUE_DEPTH  = 8
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // lock_id, client_id, retry_ok
   input  logic [CMD_W-1:0]      req_tuser,  // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // status, notify_client
   output logic [KIND_W-1:0]     rsp_tuser   // notify_kind
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;
   result_type    result;
   result_type    rsp_result_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free, rsp_load;

   // The output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load = cmd.commit | cmd.commit_pop;

   clm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_status  (dp_status),
      .out_free   (out_free),
      .cmd        (cmd)
   );

   clm_datapath #(
      .LOCK_COUNT   (LOCK_COUNT),
      .CLIENT_COUNT (CLIENT_COUNT),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_command   (req_tuser),
      .req_lock_id   (req_tdata[LOCK_ID_W-1:0]),
      .req_client_id (req_tdata[LOCK_ID_W +: CLIENT_W]),
      .req_retry_ok  (req_tdata[LOCK_ID_W + CLIENT_W]),
      .dp_status     (dp_status),
      .result        (result)
   );

   // Hold a finished result until the sink takes the transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_result_ff.client, rsp_result_ff.status};
   assign rsp_tuser  = rsp_result_ff.kind;

endmodule

// ===== rtl/clm_checker.sv =====
// Port-level checks of the lock manager and their binding to the top level.
`include "assert_macros.svh"

module clm_checker
   import clm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [KIND_W-1:0]     rsp_tuser
);

   `CLM_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")
   `CLM_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while one is in flight")
   `CLM_ASSERT_IMPLY(a_no_msg_no_client, clock, reset, rsp_tvalid && rsp_tuser == MSG_NONE, rsp_tdata[STATUS_W +: CLIENT_W] == '0, "client set without a message")
   `CLM_ASSERT_IMPLY(a_revoke_means_retry, clock, reset, rsp_tvalid && rsp_tuser == MSG_REVOKE, rsp_tdata[STATUS_W-1:0] == ST_RETRY, "revoke without retry status")

endmodule

bind caching_lock_manager_core clm_checker u_clm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/tb_caching_lock_manager_core.sv =====
// Self-checking testbench for the caching lock manager: directed and random lock traffic.
module tb_caching_lock_manager_core
   import clm_pkg::*;
;

   localparam int LOCKS       = 64;
   localparam int CLIENTS     = 16;
   localparam int QDEPTH      = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 12;

   // Command code 3 is not in the package enum; the block must ignore it.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Scoreboard: mirror of the lock table plus the queue of expected responses.
   class lock_scoreboard;
      phase_type           lock_phase   [LOCKS];
      logic [CLIENT_W-1:0] holder       [LOCKS];
      logic [CLIENT_W-1:0] waiter_slot  [LOCKS][QDEPTH];
      int                  waiter_head  [LOCKS];
      int                  waiter_count [LOCKS];
      result_type          pending_q[$];
      int                  errors;

      function new();
         foreach (lock_phase[i]) begin
            lock_phase[i]   = PH_FREE;
            holder[i]       = '0;
            waiter_head[i]  = 0;
            waiter_count[i] = 0;
         end
         errors = 0;
      endfunction

      // Apply one request to the mirrored lock table and return its response.
      function result_type apply_lock_request(logic [CMD_W-1:0] cmd, logic [LOCK_ID_W-1:0] lk,
                                              logic [CLIENT_W-1:0] cl, logic ok);
         result_type r;
         phase_type  ph;
         r.status = ST_OK;
         r.kind   = MSG_NONE;
         r.client = '0;
         ph = lock_phase[lk];
         case (cmd)
            CMD_ACQUIRE: begin
               if (ph == PH_FREE) begin
                  holder[lk]     = cl;
                  lock_phase[lk] = PH_HELD;
               end else if (waiter_count[lk] >= QDEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  waiter_slot[lk][(waiter_head[lk] + waiter_count[lk]) % QDEPTH] = cl;
                  waiter_count[lk]++;
                  r.status = ST_RETRY;
                  if (ph == PH_HELD) begin
                     lock_phase[lk] = PH_REVOKING;
                     r.kind         = MSG_REVOKE;
                     r.client       = holder[lk];
                  end
               end
            end
            CMD_RELEASE: begin
               if (ph == PH_FREE || holder[lk] != cl) begin
                  r.status = ST_NOT_HOLDER;
               end else if (waiter_count[lk] != 0) begin
                  // hand the lock to the queue head
                  holder[lk]       = waiter_slot[lk][waiter_head[lk]];
                  waiter_head[lk]  = (waiter_head[lk] + 1) % QDEPTH;
                  waiter_count[lk]--;
                  lock_phase[lk]   = PH_HANDOVER;
                  r.kind           = MSG_RETRY;
                  r.client         = holder[lk];
               end else begin
                  lock_phase[lk] = PH_FREE;
               end
            end
            CMD_RETRY_RESULT: begin
               if (ok && ph == PH_HANDOVER) begin
                  if (holder[lk] != cl) r.status = ST_NOT_HOLDER;
                  else lock_phase[lk] = PH_HELD;
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [LOCK_ID_W-1:0] lk,
                                 logic [CLIENT_W-1:0] cl, logic ok);
         pending_q.push_back(apply_lock_request(cmd, lk, cl, ok));
      endfunction

      task report_mismatch(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_response(result_type got);
         result_type want;
         if (pending_q.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = pending_q.pop_front();
            if (got.status !== want.status)
               report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.kind !== want.kind)
               report_mismatch($sformatf("notify_kind got %0d want %0d", got.kind, want.kind));
            if (got.client !== want.client)
               report_mismatch($sformatf("notify_client got %0d want %0d",
                                         got.client, want.client));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // lock_id[5:0], client_id[9:6], retry_ok[10]
   logic [CMD_W-1:0]      req_tuser;   // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // status[1:0], notify_client[5:2]
   logic [KIND_W-1:0]     rsp_tuser;   // notify_kind

   lock_scoreboard sb = new();
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;
   int cycle_count = 0;

   caching_lock_manager_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Timeout watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Stall the response channel at random; change only on the falling edge.
   always @(negedge clock) begin
      rsp_tready = ($urandom_range(99) >= receiver_stall_pct);
   end

   // Sample both channels at the rising edge. Check the response first: it always
   // belongs to an older request than one accepted at the same edge.
   always @(posedge clock) begin
      result_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tdata[STATUS_W-1:0]);
            got.client = rsp_tdata[STATUS_W +: CLIENT_W];
            got.kind   = kind_type'(rsp_tuser);
            sb.check_response(got);
         end
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[LOCK_ID_W-1:0],
                            req_tdata[LOCK_ID_W +: CLIENT_W],
                            req_tdata[LOCK_ID_W + CLIENT_W]);
      end
   end

   // Present one request and hold it until the transfer completes.
   // Enter and leave on a falling edge.
   task send_request(input logic [CMD_W-1:0] cmd, input logic [LOCK_ID_W-1:0] lk,
                     input logic [CLIENT_W-1:0] cl, input logic ok);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = '0;
      req_tdata[LOCK_ID_W-1:0]         = lk;
      req_tdata[LOCK_ID_W +: CLIENT_W] = cl;
      req_tdata[LOCK_ID_W + CLIENT_W]  = ok;
      req_tuser  = cmd;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and hold off until every outstanding response has come back.
   task drain_responses();
      req_tvalid = 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
   endtask

   // Random traffic: mostly protocol-shaped sequences on a few hot locks,
   // the rest arbitrary requests anywhere in the table.
   task run_random(input int count);
      logic [LOCK_ID_W-1:0] hot_locks [4];
      logic [LOCK_ID_W-1:0] lk;
      logic [CLIENT_W-1:0]  cl;
      logic [CMD_W-1:0]     cmd;
      logic                 ok;
      int                   roll;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0)
            foreach (hot_locks[i]) hot_locks[i] = LOCK_ID_W'($urandom_range(LOCKS-1));
         lk   = ($urandom_range(9) < 8) ? hot_locks[$urandom_range(3)]
                                        : LOCK_ID_W'($urandom_range(LOCKS-1));
         cl   = CLIENT_W'($urandom_range(CLIENTS-1));
         ok   = 1'($urandom_range(1));
         cmd  = CMD_ACQUIRE;
         roll = $urandom_range(99);
         if ($urandom_range(99) < 75) begin
            case (sb.lock_phase[lk])
               PH_FREE: cmd = CMD_ACQUIRE;
               PH_HELD: if (roll < 50) begin
                  cmd = CMD_RELEASE;
                  cl  = sb.holder[lk];
               end
               PH_REVOKING: if (roll < 35) begin
                  cmd = CMD_RELEASE;
                  cl  = sb.holder[lk];
               end
               PH_HANDOVER: if (roll < 60) begin
                  cmd = CMD_RETRY_RESULT;
                  cl  = sb.holder[lk];
                  ok  = ($urandom_range(9) != 0);
               end else if (roll < 75) begin
                  cmd = CMD_RELEASE;
                  cl  = sb.holder[lk];
               end
               default: ;
            endcase
         end else begin
            cmd = CMD_W'($urandom_range(3));
            lk  = LOCK_ID_W'($urandom_range(LOCKS-1));
         end
         send_request(cmd, lk, cl, ok);
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Sender idles often, receiver stalls more.
      sender_idle_pct    = 26;
      receiver_stall_pct = 77;

      // Directed: extremes, every command, each corner of the lock protocol.
      send_request(CMD_ACQUIRE,      6'd63, 4'd15, 1'b0); // grant free lock
      send_request(CMD_RELEASE,      6'd0,  4'd0,  1'b0); // release of a free lock
      send_request(CMD_ACQUIRE,      6'd0,  4'd0,  1'b0);
      send_request(CMD_RELEASE,      6'd0,  4'd1,  1'b0); // not the holder
      send_request(CMD_ACQUIRE,      6'd0,  4'd5,  1'b0); // revoke to client 0
      send_request(CMD_ACQUIRE,      6'd0,  4'd10, 1'b0); // queue while revoking
      send_request(CMD_RETRY_RESULT, 6'd0,  4'd5,  1'b1); // not in handover: ignored
      send_request(CMD_RELEASE,      6'd0,  4'd0,  1'b1); // release while revoking
      send_request(CMD_ACQUIRE,      6'd0,  4'd3,  1'b0); // queue during handover
      send_request(CMD_RETRY_RESULT, 6'd0,  4'd10, 1'b1); // retry from non-holder
      send_request(CMD_RETRY_RESULT, 6'd0,  4'd5,  1'b0); // retry refused
      send_request(CMD_RELEASE,      6'd0,  4'd5,  1'b0); // release in handover
      send_request(CMD_RETRY_RESULT, 6'd0,  4'd10, 1'b1); // retry accepted
      send_request(CMD_UNUSED,       6'd42, 4'd9,  1'b1); // unused command
      send_request(CMD_ACQUIRE,      6'd21, 4'd7,  1'b0);
      send_request(CMD_RELEASE,      6'd21, 4'd7,  1'b0); // free with empty queue
      // Fill the queue of lock 63 and overflow it once.
      for (int c = 1; c <= QDEPTH + 1; c++)
         send_request(CMD_ACQUIRE, 6'd63, c[CLIENT_W-1:0], 1'b0);
      send_request(CMD_RELEASE, 6'd63, 4'd15, 1'b0);

      run_random(170);
      drain_responses();

      // Swap the idle rates.
      sender_idle_pct    = 77;
      receiver_stall_pct = 26;
      run_random(170);
      drain_responses();

      // Full rate on both sides.
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_random(170);
      drain_responses();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== caching_lock_manager_core.f =====
+incdir+rtl
rtl/clm_pkg.sv
rtl/clm_ctrl.sv
rtl/clm_datapath.sv
rtl/caching_lock_manager_core.sv
rtl/clm_checker.sv
tb/tb_caching_lock_manager_core.sv
